### rtl/ufsc_pkg.sv
package ufsc_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_FRAME_MODE   = 2'd0;
	localparam logic [1:0] REG_VALUE_OFFSET = 2'd1;

	// frame layout
	localparam logic [7:0] HDR_FF    = 8'hFF;
	localparam logic [7:0] HDR_AA    = 8'hAA;
	localparam logic [3:0] LAST_XOR  = 4'd13;
	localparam logic [3:0] LAST_SUM  = 4'd14;
	localparam logic [3:0] OFFSET_RESET = 4'd3;

	// angle unwrapping
	localparam int STEP_LIMIT = 34000;
	localparam int TURN       = 36000;

	// default sizes
	localparam int FRAME_BYTES_DEF   = 16;
	localparam int ROTATION_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF   = 4;

	// header hunt phases
	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SECOND,
		PH_COLLECT
	} phase_t;

	// one finished frame as handed from front to back
	typedef struct packed {
		logic        status;
		logic        mode;
		logic [15:0] word;
	} frame_rec_t;

endpackage

### rtl/ufsc_front.sv
module ufsc_front #(
	parameter int FRAME_BYTES = ufsc_pkg::FRAME_BYTES_DEF,
	parameter int QUEUE_DEPTH = ufsc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rx_valid,
	output logic                               rx_stall,
	input  logic [7:0]                         rx_byte,
	input  logic                               cfg_valid,
	input  logic [1:0]                         cfg_index,
	input  logic [3:0]                         cfg_data,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_level,
	output logic                               push,
	output ufsc_pkg::frame_rec_t               push_rec
);

	localparam int AW = $clog2(FRAME_BYTES);

	typedef enum logic [1:0] {
		SRC_MEM,
		SRC_LAST,
		SRC_ZERO
	} src_t;

	ufsc_pkg::phase_t phase_q, phase_d;
	logic [3:0] idx_q, idx_d;
	logic [7:0] acc_q, acc_d;
	logic       mode_q;
	logic [3:0] off_q;

	logic [7:0] mem [FRAME_BYTES];
	logic          we;
	logic [AW-1:0] waddr;
	logic          fin;
	logic          rx_acc;
	logic          cfg_mode_wr;
	logic [3:0]    last;
	logic [4:0]    lo_pos, hi_pos;

	logic       v_s1;
	logic       status_s1, mode_s1;
	logic [7:0] b_s1, rd_lo_s1, rd_hi_s1;
	src_t       lo_src_s1, hi_src_s1;
	logic [7:0] lo_byte, hi_byte;

	// where a byte of the value comes from at the end of a frame
	function automatic src_t byte_src(input logic [4:0] pos, input logic [3:0] lst);
		src_t r;
		if (pos == {1'b0, lst})
			r = SRC_LAST;
		else if (pos > {1'b0, lst})
			r = SRC_ZERO;
		else
			r = SRC_MEM;
		return r;
	endfunction

	// stall while queued plus finishing frames reach depth minus one
	assign rx_stall    = (int'(q_level) + int'(v_s1)) >= (QUEUE_DEPTH - 1);
	assign rx_acc      = rx_valid && !rx_stall;
	assign cfg_mode_wr = cfg_valid && (cfg_index == ufsc_pkg::REG_FRAME_MODE);
	assign last        = mode_q ? ufsc_pkg::LAST_SUM : ufsc_pkg::LAST_XOR;
	assign lo_pos      = {1'b0, off_q};
	assign hi_pos      = {1'b0, off_q} + 5'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			off_q  <= ufsc_pkg::OFFSET_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ufsc_pkg::REG_FRAME_MODE:   mode_q <= cfg_data[0];
				ufsc_pkg::REG_VALUE_OFFSET: off_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// header hunt and frame collection
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		acc_d   = acc_q;
		we      = 1'b0;
		waddr   = AW'(idx_q);
		fin     = 1'b0;
		if (rx_acc) begin
			case (phase_q)
				ufsc_pkg::PH_COLLECT: begin
					we = 1'b1;
					if (idx_q < last) begin
						if (idx_q >= 4'd2)
							acc_d = mode_q ? acc_q + rx_byte : acc_q ^ rx_byte;
						idx_d = idx_q + 4'd1;
					end else begin
						fin     = 1'b1;
						phase_d = ufsc_pkg::PH_HUNT;
						idx_d   = '0;
						acc_d   = '0;
					end
				end
				ufsc_pkg::PH_SECOND: begin
					if (rx_byte == ufsc_pkg::HDR_FF) begin
						we      = 1'b1;
						waddr   = AW'(1);
						idx_d   = 4'd2;
						acc_d   = '0;
						phase_d = ufsc_pkg::PH_COLLECT;
					end else begin
						phase_d = ufsc_pkg::PH_HUNT;
					end
				end
				default: begin
					phase_d = ufsc_pkg::PH_HUNT;
					if (!mode_q) begin
						if (rx_byte == ufsc_pkg::HDR_FF) begin
							we      = 1'b1;
							waddr   = '0;
							phase_d = ufsc_pkg::PH_SECOND;
						end
					end else if (rx_byte == ufsc_pkg::HDR_AA) begin
						we      = 1'b1;
						waddr   = '0;
						idx_d   = 4'd1;
						acc_d   = '0;
						phase_d = ufsc_pkg::PH_COLLECT;
					end
				end
			endcase
		end
		// a mode change drops any partial frame
		if (cfg_mode_wr) begin
			phase_d = ufsc_pkg::PH_HUNT;
			idx_d   = '0;
			acc_d   = '0;
		end
	end

	// hunt state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ufsc_pkg::PH_HUNT;
			idx_q   <= '0;
			acc_q   <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			acc_q   <= acc_d;
		end
	end

	// frame byte store
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= rx_byte;
	end

	// finish stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= fin;
	end

	// finish stage payload and store reads
	always_ff @(posedge clk) begin
		if (fin) begin
			status_s1 <= (acc_q != rx_byte);
			mode_s1   <= mode_q;
			b_s1      <= rx_byte;
			lo_src_s1 <= byte_src(lo_pos, last);
			hi_src_s1 <= byte_src(hi_pos, last);
			rd_lo_s1  <= mem[lo_pos[AW-1:0]];
			rd_hi_s1  <= mem[hi_pos[AW-1:0]];
		end
	end

	// pick the value bytes
	always_comb begin
		case (lo_src_s1)
			SRC_MEM:  lo_byte = rd_lo_s1;
			SRC_LAST: lo_byte = b_s1;
			default:  lo_byte = '0;
		endcase
		case (hi_src_s1)
			SRC_MEM:  hi_byte = rd_hi_s1;
			SRC_LAST: hi_byte = b_s1;
			default:  hi_byte = '0;
		endcase
	end

	assign push            = v_s1;
	assign push_rec.status = status_s1;
	assign push_rec.mode   = mode_s1;
	assign push_rec.word   = {hi_byte, lo_byte};

	// accumulator is clear whenever no frame is open
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != ufsc_pkg::PH_COLLECT) |-> (acc_q == 8'd0))
		else $error("checksum accumulator not clear outside a frame");

	// byte index stays inside the frame while collecting
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ufsc_pkg::PH_COLLECT) |-> (idx_q >= 4'd1 && idx_q <= ufsc_pkg::LAST_SUM))
		else $error("byte index outside the frame");

	// two frames cannot finish on consecutive cycles
	a_fin_gap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> !v_s1)
		else $error("frames finished back to back");

endmodule

### rtl/ufsc_queue.sv
module ufsc_queue #(
	parameter int QUEUE_DEPTH = ufsc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  ufsc_pkg::frame_rec_t              push_rec,
	input  logic                              pop,
	output ufsc_pkg::frame_rec_t              head_rec,
	output logic                              nonempty,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]  level
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	ufsc_pkg::frame_rec_t ent_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [LW-1:0] level_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (int'(p) == QUEUE_DEPTH - 1)
			r = '0;
		else
			r = p + PW'(1);
		return r;
	endfunction

	assign head_rec = ent_q[rd_ptr_q];
	assign nonempty = (level_q != '0);
	assign level    = level_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_rec;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				level_q <= level_q + LW'(1);
			else if (pop && !push)
				level_q <= level_q - LW'(1);
		end
	end

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (int'(level_q) < QUEUE_DEPTH))
		else $error("push into full queue");

	// no pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from empty queue");

	// a push without a pop raises the level by one
	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (level_q == $past(level_q) + LW'(1)))
		else $error("queue level did not follow a push");

endmodule

### rtl/ufsc_back.sv
module ufsc_back #(
	parameter int ROTATION_BITS = ufsc_pkg::ROTATION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ufsc_pkg::frame_rec_t  head_rec,
	input  logic                  nonempty,
	output logic                  pop,
	output logic                  frame_valid,
	input  logic                  frame_stall,
	output logic                  frame_status,
	output logic signed [15:0]    value_word,
	output logic signed [31:0]    unwrapped_angle
);

	localparam int RB = ROTATION_BITS;

	logic [RB-1:0] rot_q;
	logic [15:0]   prev_q;

	logic                 adv;
	logic [15:0]          neg;
	logic signed [16:0]   step;
	logic                 good;
	logic [RB-1:0]        rc_new, rc_d;
	logic [15:0]          pa_d;

	logic                 v_s1, v_s2, out_v_q;
	logic                 st_s1, st_s2, st_q;
	logic [15:0]          word_s1, word_s2, word_q;
	logic [RB-1:0]        rc_s1;
	logic [15:0]          pa_s1, pa_s2;
	logic signed [31:0]   prod_s2, angle_q;

	assign adv = !out_v_q || !frame_stall;
	assign pop = adv && nonempty;

	// value negation (frame mode 1 only) and angle step
	always_comb begin
		neg    = head_rec.mode ? 16'(16'd0 - head_rec.word) : head_rec.word;
		step   = {neg[15], neg} - {prev_q[15], prev_q};
		good   = head_rec.mode && !head_rec.status;
		rc_new = rot_q;
		if (int'(step) < -ufsc_pkg::STEP_LIMIT)
			rc_new = rot_q + RB'(1);
		else if (int'(step) > ufsc_pkg::STEP_LIMIT)
			rc_new = rot_q - RB'(1);
		if (!head_rec.mode) begin
			rc_d = '0;
			pa_d = '0;
		end else if (good) begin
			rc_d = rc_new;
			pa_d = neg;
		end else begin
			rc_d = rot_q;
			pa_d = prev_q;
		end
	end

	// rotation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q  <= '0;
			prev_q <= '0;
		end else if (pop && good) begin
			rot_q  <= rc_new;
			prev_q <= neg;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= nonempty;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	// pipeline payload: decode, multiply, add
	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1   <= head_rec.status;
			word_s1 <= neg;
			rc_s1   <= rc_d;
			pa_s1   <= pa_d;
			st_s2   <= st_s1;
			word_s2 <= word_s1;
			pa_s2   <= pa_s1;
			prod_s2 <= 32'(signed'(rc_s1)) * 32'(ufsc_pkg::TURN);
			st_q    <= st_s2;
			word_q  <= word_s2;
			angle_q <= prod_s2 + 32'(signed'(pa_s2));
		end
	end

	assign frame_valid     = out_v_q;
	assign frame_status    = st_q;
	assign value_word      = signed'(word_q);
	assign unwrapped_angle = angle_q;

	// rotation state only moves on a popped good frame
	a_rot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && good) |=> ($stable(rot_q) && $stable(prev_q)))
		else $error("rotation state changed without a good frame");

	// a stalled pipeline does not pop
	a_hold_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && frame_stall) |-> !pop)
		else $error("pop while output is stalled");

	// a step inside the limits leaves the count alone
	a_small_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && good && int'(step) >= -ufsc_pkg::STEP_LIMIT
			&& int'(step) <= ufsc_pkg::STEP_LIMIT) |=> (rot_q == $past(rot_q)))
		else $error("rotation count moved on a small step");

endmodule

### rtl/uart_frame_sync_checksum.sv
// channel   dir   handshake                   payload
// rx        in    rx_valid / rx_stall         rx_byte
// frame     out   frame_valid / frame_stall   frame_status, value_word, unwrapped_angle
// cfg       in    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// one byte is taken per cycle while rx_stall is low
// the byte store and the checksum update in the front part set the one-byte-per-cycle pace
// rx_stall rises when queued plus finishing frames come within one entry of a full queue
// a stalled result holds the back pipeline; bytes keep flowing until rx_stall rises
// arst_n clears hunt state, queue, rotation count and previous angle; cfg_ready is always high
module uart_frame_sync_checksum #(
	parameter int FRAME_BYTES   = ufsc_pkg::FRAME_BYTES_DEF,
	parameter int ROTATION_BITS = ufsc_pkg::ROTATION_BITS_DEF,
	parameter int QUEUE_DEPTH   = ufsc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  logic [7:0]         rx_byte,
	output logic               frame_valid,
	input  logic               frame_stall,
	output logic               frame_status,
	output logic signed [15:0] value_word,
	output logic signed [31:0] unwrapped_angle,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [3:0]         cfg_data
);

	logic                                push;
	ufsc_pkg::frame_rec_t                push_rec;
	logic                                pop;
	ufsc_pkg::frame_rec_t                head_rec;
	logic                                nonempty;
	logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_level;

	assign cfg_ready = 1'b1;

	// header hunt, byte store, checksum
	ufsc_front #(
		.FRAME_BYTES (FRAME_BYTES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_level   (q_level),
		.push      (push),
		.push_rec  (push_rec)
	);

	// finished frames waiting for the back part
	ufsc_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.nonempty (nonempty),
		.level    (q_level)
	);

	// value negation, angle unwrapping, result register
	ufsc_back #(
		.ROTATION_BITS (ROTATION_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_rec        (head_rec),
		.nonempty        (nonempty),
		.pop             (pop),
		.frame_valid     (frame_valid),
		.frame_stall     (frame_stall),
		.frame_status    (frame_status),
		.value_word      (value_word),
		.unwrapped_angle (unwrapped_angle)
	);

endmodule

### sim/tb_top.sv
module tb_top;

	// register indexes with no register behind them
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;

	localparam int CLK_HALF    = 6;
	localparam int RANDOM_GOAL = 1400;
	localparam int PHASE_BYTES = 200;
	localparam int SETTLE_CYC  = 8;

	// one finished frame as seen on the output channel
	typedef struct packed {
		logic        status;
		logic [15:0] word;
		logic [31:0] angle;
	} frame_result_t;

	// one directed frame, with the result typed in where it is obvious
	typedef struct packed {
		logic        mode;
		logic [3:0]  offset;
		logic [15:0] val;
		logic        corrupt;
		logic        lead_break;
		logic        typed;
		logic        status;
		logic [15:0] word;
		logic [31:0] angle;
	} frame_row_t;

	logic               clk;
	logic               arst_n;
	logic               rx_valid;
	logic               rx_stall;
	logic [7:0]         rx_byte;
	logic               frame_valid;
	logic               frame_stall;
	logic               frame_status;
	logic signed [15:0] value_word;
	logic signed [31:0] unwrapped_angle;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [3:0]         cfg_data;

	// frame sync predictor state
	logic               sync_mode;
	logic [3:0]         sync_offset;
	ufsc_pkg::phase_t   sync_phase;
	logic [3:0]         sync_pos;
	logic [7:0]         sync_check;
	logic [7:0]         sync_bytes [16];
	logic signed [15:0] last_angle;
	logic signed [15:0] turns;

	frame_result_t expected_frames [$];
	frame_result_t typed_result;
	bit            typed_pending;
	int            errors;
	int            bytes_sent;
	int            idle_pct;
	int            stall_pct;

	uart_frame_sync_checksum uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_byte        (rx_byte),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.frame_status   (frame_status),
		.value_word     (value_word),
		.unwrapped_angle(unwrapped_angle),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// hard stop
	initial begin
		#(2 * CLK_HALF * 600000);
		$display("FAILURE");
		$finish;
	end

	// receiver stall
	initial begin
		frame_stall = 1'b0;
		forever begin
			@(negedge clk);
			frame_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// advance the frame predictor by one byte, returns 1 when a frame completes
	function automatic bit sync_on_byte(input logic [7:0] b, output frame_result_t r);
		logic [3:0]  last_pos;
		logic [4:0]  p;
		logic [15:0] w;
		int          delta;
		last_pos = sync_mode ? ufsc_pkg::LAST_SUM : ufsc_pkg::LAST_XOR;
		r = '0;
		// header hunt
		if (sync_phase != ufsc_pkg::PH_COLLECT) begin
			if (sync_phase == ufsc_pkg::PH_SECOND) begin
				if (b == ufsc_pkg::HDR_FF) begin
					sync_bytes[1] = ufsc_pkg::HDR_FF;
					sync_pos = 4'd2;
					sync_check = 8'd0;
					sync_phase = ufsc_pkg::PH_COLLECT;
				end else begin
					sync_phase = ufsc_pkg::PH_HUNT;
				end
			end else if (!sync_mode) begin
				sync_phase = (b == ufsc_pkg::HDR_FF) ?
					ufsc_pkg::PH_SECOND : ufsc_pkg::PH_HUNT;
				if (b == ufsc_pkg::HDR_FF)
					sync_bytes[0] = ufsc_pkg::HDR_FF;
			end else begin
				sync_phase = ufsc_pkg::PH_HUNT;
				if (b == ufsc_pkg::HDR_AA) begin
					sync_bytes[0] = ufsc_pkg::HDR_AA;
					sync_pos = 4'd1;
					sync_check = 8'd0;
					sync_phase = ufsc_pkg::PH_COLLECT;
				end
			end
			return 1'b0;
		end
		// body bytes
		sync_bytes[sync_pos] = b;
		if (sync_pos < last_pos) begin
			if (sync_pos >= 4'd2)
				sync_check = sync_mode ? sync_check + b : sync_check ^ b;
			sync_pos = sync_pos + 4'd1;
			return 1'b0;
		end
		// last byte: check, value read, angle unwrap
		r.status = (sync_check != b);
		p = {1'b0, sync_offset};
		w[7:0] = (p <= {1'b0, last_pos}) ? sync_bytes[p[3:0]] : 8'd0;
		p = p + 5'd1;
		w[15:8] = (p <= {1'b0, last_pos}) ? sync_bytes[p[3:0]] : 8'd0;
		if (sync_mode) begin
			w = -w;
			if (!r.status) begin
				delta = int'($signed(w)) - int'(last_angle);
				if (delta < -ufsc_pkg::STEP_LIMIT)
					turns = turns + 16'sd1;
				if (delta > ufsc_pkg::STEP_LIMIT)
					turns = turns - 16'sd1;
				last_angle = w;
			end
			r.angle = int'(turns) * ufsc_pkg::TURN + int'(last_angle);
		end
		r.word = w;
		sync_phase = ufsc_pkg::PH_HUNT;
		sync_pos = 4'd0;
		sync_check = 8'd0;
		return 1'b1;
	endfunction

	// one rx transaction, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		frame_result_t r;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			rx_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		if (sync_on_byte(b, r)) begin
			if (typed_pending) begin
				r = typed_result;
				typed_pending = 1'b0;
			end
			expected_frames.push_back(r);
		end
		bytes_sent++;
	endtask

	// whole frame in the current mode, value placed at the current offset where it falls inside the checksummed body
	task automatic send_frame(input logic [15:0] val, input bit corrupt);
		logic [7:0] fb [16];
		logic [7:0] chk;
		int         last_pos;
		int         o;
		last_pos = sync_mode ? ufsc_pkg::LAST_SUM : ufsc_pkg::LAST_XOR;
		o = sync_offset;
		fb[0] = sync_mode ? ufsc_pkg::HDR_AA : ufsc_pkg::HDR_FF;
		fb[1] = ufsc_pkg::HDR_FF;
		// body, with header bytes now and then
		for (int i = sync_mode ? 1 : 2; i < last_pos; i++)
			fb[i] = ($urandom_range(7) == 0) ? fb[0] : 8'($urandom_range(255));
		if (o >= 2 && o < last_pos)
			fb[o] = val[7:0];
		if (o + 1 >= 2 && o + 1 < last_pos)
			fb[o + 1] = val[15:8];
		chk = 8'd0;
		for (int i = 2; i < last_pos; i++)
			chk = sync_mode ? chk + fb[i] : chk ^ fb[i];
		fb[last_pos] = corrupt ? chk ^ 8'($urandom_range(255, 1)) : chk;
		for (int i = 0; i <= last_pos; i++)
			send_byte(fb[i]);
	endtask

	// one cfg transaction
	task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ufsc_pkg::REG_FRAME_MODE: begin
				sync_mode = data[0];
				sync_phase = ufsc_pkg::PH_HUNT;
				sync_pos = 4'd0;
				sync_check = 8'd0;
			end
			ufsc_pkg::REG_VALUE_OFFSET: begin
				sync_offset = data;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold the sender until every frame is out and the pipeline is quiet
	task automatic settle();
		@(negedge clk);
		rx_valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic configure(input logic mode, input logic [3:0] offset);
		settle();
		write_reg(ufsc_pkg::REG_FRAME_MODE, {3'($urandom_range(7)), mode});
		write_reg(ufsc_pkg::REG_VALUE_OFFSET, offset);
		write_reg(REG_SPARE_2, 4'($urandom));
		write_reg(REG_SPARE_3, 4'($urandom));
	endtask

	// output checking against the oldest expected frame
	always @(posedge clk) begin : check_frames
		frame_result_t want;
		if (arst_n && frame_valid && !frame_stall) begin
			if (expected_frames.size() == 0) begin
				$display("%0t unexpected frame: status %0d word %0d angle %0d", $time,
					frame_status, value_word, unwrapped_angle);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				if (frame_status !== want.status) begin
					$display("%0t frame_status expected %0d actual %0d", $time,
						want.status, frame_status);
					errors++;
				end
				if (value_word !== want.word) begin
					$display("%0t value_word expected %0d actual %0d", $time,
						$signed(want.word), value_word);
					errors++;
				end
				if (unwrapped_angle !== want.angle) begin
					$display("%0t unwrapped_angle expected %0d actual %0d", $time,
						$signed(want.angle), unwrapped_angle);
					errors++;
				end
			end
		end
	end

	initial begin : main
		frame_row_t  plan [0:7];
		int          phase_end;
		int          random_end;
		int          ph;
		int          pick;
		logic        mode;
		logic [3:0]  offset;
		logic [15:0] val;

		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = ufsc_pkg::REG_FRAME_MODE;
		cfg_data = 4'd0;
		errors = 0;
		bytes_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		typed_pending = 1'b0;
		sync_mode = 1'b0;
		sync_offset = ufsc_pkg::OFFSET_RESET;
		sync_phase = ufsc_pkg::PH_HUNT;
		sync_pos = 4'd0;
		sync_check = 8'd0;
		last_angle = 16'sd0;
		turns = 16'sd0;
		for (int i = 0; i < 16; i++)
			sync_bytes[i] = 8'd0;

		// mode, offset, value, corrupt, broken header first, typed, status, word, angle
		plan = '{
			'{1'b0, 4'd3,  16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 32'h0000_0000},
			'{1'b0, 4'd3,  16'h7FFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'h7FFF, 32'h0000_0000},
			'{1'b0, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 16'hFFFF, 32'h0000_0000},
			'{1'b0, 4'd13, 16'h1234, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
			'{1'b1, 4'd3,  16'h8000, 1'b0, 1'b0, 1'b1, 1'b0, 16'h8000, 32'hFFFF_8000},
			'{1'b1, 4'd3,  16'h8001, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
			'{1'b1, 4'd15, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000},
			'{1'b1, 4'd1,  16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 32'h0000_0000}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed frames, first one on reset settings
		foreach (plan[i]) begin
			if (plan[i].mode != sync_mode || plan[i].offset != sync_offset)
				configure(plan[i].mode, plan[i].offset);
			if (plan[i].lead_break) begin
				send_byte(ufsc_pkg::HDR_FF);
				send_byte(8'h00);
			end
			typed_pending = plan[i].typed;
			typed_result = '{plan[i].status, plan[i].word, plan[i].angle};
			send_frame(plan[i].val, plan[i].corrupt);
		end

		// random phases, each with its own settings and idling mix
		random_end = bytes_sent + RANDOM_GOAL;
		ph = 0;
		while (bytes_sent < random_end) begin
			case (ph)
				0: begin mode = 1'b0; offset = 4'd0; end
				1: begin mode = 1'b1; offset = 4'd12; end
				2: begin mode = 1'b1; offset = 4'd15; end
				3: begin mode = 1'b0; offset = 4'd13; end
				4: begin mode = 1'b0; offset = 4'd12; end
				default: begin
					mode = 1'($urandom);
					offset = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
						4'($urandom_range(11, 2));
				end
			endcase
			configure(mode, offset);
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 63; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 63; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					// angles across the range, a quarter of the draws near the half-turn edges that make the count move
					case ($urandom_range(3))
						0: val = 16'($urandom_range(36000) - 18000);
						1: val = $urandom_range(1) ? 16'(18000 - $urandom_range(300)) :
							16'($urandom_range(300) - 18000);
						2: val = 16'($urandom);
						default: val = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
					endcase
					send_frame(val, $urandom_range(9) == 0);
				end else if (pick < 90) begin
					// broken header or cut-short frame
					if (!sync_mode && $urandom_range(1)) begin
						send_byte(ufsc_pkg::HDR_FF);
						send_byte(8'($urandom_range(254)));
					end else begin
						send_byte(sync_mode ? ufsc_pkg::HDR_AA : ufsc_pkg::HDR_FF);
						if (!sync_mode)
							send_byte(ufsc_pkg::HDR_FF);
						repeat ($urandom_range(12, 1)) send_byte(8'($urandom));
					end
				end else begin
					repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
				end
			end
			ph++;
		end

		settle();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
